// ----- hdl/u8hex_pkg.sv -----
// Shared types, constants and decode helpers for the UTF-8 to UTF-16BE hex transcoder.
package u8hex_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_UNITS   = 3;

   localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
   localparam logic [7:0]  MASK_LEAD2    = 8'hE0;
   localparam logic [7:0]  PFX_LEAD2     = 8'hC0;
   localparam logic [7:0]  MASK_LEAD3    = 8'hF0;
   localparam logic [7:0]  PFX_LEAD3     = 8'hE0;
   localparam logic [7:0]  MASK_LEAD4    = 8'hF8;
   localparam logic [7:0]  PFX_LEAD4     = 8'hF0;
   localparam logic [15:0] QMARK_UNIT    = 16'h003F;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [15:0] SURR_HI_BASE  = 16'hD800;
   localparam logic [15:0] SURR_LO_BASE  = 16'hDC00;
   localparam logic [6:0]  ASCII_ZERO    = 7'h30;
   localparam logic [6:0]  ASCII_ALPHA   = 7'h37;  // 'A' - 10

   // One queue entry: the code units caused by one input byte.
   typedef struct packed {
      logic [MAX_UNITS-1:0][15:0] units;
      logic [1:0]                 count;
      logic                       text_end;
   } group_type;

   // Sequence length that a lead byte calls for; 0 marks an invalid lead.
   function automatic logic [2:0] lead_len(input logic [7:0] c);
      logic [2:0] len;
      if (c < ASCII_LIMIT)                     len = 3'd1;
      else if ((c & MASK_LEAD2) == PFX_LEAD2)  len = 3'd2;
      else if ((c & MASK_LEAD3) == PFX_LEAD3)  len = 3'd3;
      else if ((c & MASK_LEAD4) == PFX_LEAD4)  len = 3'd4;
      else                                     len = 3'd0;
      return len;
   endfunction

   // Unit for a byte that stands alone: ASCII passes, anything else is '?'.
   function automatic logic [15:0] single_unit(input logic [7:0] c);
      logic [15:0] u;
      if (c < ASCII_LIMIT) u = {8'h00, c};
      else                 u = QMARK_UNIT;
      return u;
   endfunction

   function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib < 4'd10) ch = ASCII_ZERO + {3'b000, nib};
      else             ch = ASCII_ALPHA + {3'b000, nib};
      return ch;
   endfunction

endpackage

// ----- hdl/utf8_to_utf16be_hex.sv -----
// Top level of the UTF-8 to UTF-16BE hex transcoder.
// Takes one UTF-8 byte per item and returns each UTF-16BE code unit as four uppercase
// ASCII hex characters, high nibble first; run_last marks the final character caused by
// a byte and text_done the final character of the string. The front end accepts a byte
// every cycle while the group queue (FIFO_DEPTH entries) has room; bytes of an unfinished
// sequence are held and produce nothing until the sequence completes. The back end sends
// one character per cycle while the receiver is ready, four characters per code unit that a
// byte causes: one unit for ASCII or a BMP character, two for a surrogate pair, up to three
// when a string ends inside a sequence, so the output serializer sets the sustained rate.
module utf8_to_utf16be_hex #(
   parameter int FIFO_DEPTH = u8hex_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_hex_char,
   output logic       rsp_run_last,
   output logic       rsp_text_done
);

   u8hex_pkg::group_type push_group, pop_group;
   logic push, pop, queue_full, queue_not_empty;

   u8hex_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .queue_full     (queue_full),
      .push           (push),
      .push_group     (push_group)
   );

   u8hex_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .pop_group  (pop_group),
      .not_empty  (queue_not_empty)
   );

   u8hex_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_group     (pop_group),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hex_char    (rsp_hex_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_done   (rsp_text_done)
   );

endmodule

// ----- hdl/u8hex_front.sv -----
// Front end: takes bytes, holds unfinished sequences and forms groups of UTF-16 code units.
module u8hex_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_string_end,
   input  logic                   queue_full,
   output logic                   push,
   output u8hex_pkg::group_type   push_group
);

   logic [1:0] pcount_ff, pcount_in;
   logic [2:0] seqlen_ff, seqlen_in;
   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];

   logic        accept;
   logic [2:0]  new_len;
   logic        seq_full;
   logic [7:0]  c1, c2, x0, x1;
   logic [20:0] cp, cp_off;
   logic [15:0] surr_hi, surr_lo;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign new_len   = u8hex_pkg::lead_len(req_data_byte);
   assign seq_full  = (({1'b0, pcount_ff} + 3'd1) == seqlen_ff);

   // continuation bytes of the held sequence, the new byte in its slot
   assign c1 = (pcount_ff == 2'd1) ? req_data_byte : pend_ff[1];
   assign c2 = (pcount_ff == 2'd2) ? req_data_byte : pend_ff[2];
   // bytes after a truncated lead, decoded again at string end
   assign x0 = (pcount_ff == 2'd1) ? req_data_byte : pend_ff[1];
   assign x1 = req_data_byte;

   always_comb begin
      case (seqlen_ff)
         3'd2:    cp = {10'd0, pend_ff[0][4:0], c1[5:0]};
         3'd3:    cp = {5'd0, pend_ff[0][3:0], c1[5:0], c2[5:0]};
         default: cp = {pend_ff[0][2:0], c1[5:0], c2[5:0], req_data_byte[5:0]};
      endcase
   end

   assign cp_off  = cp - u8hex_pkg::SUPP_BASE;
   assign surr_hi = u8hex_pkg::SURR_HI_BASE + {5'd0, cp_off[20:10]};
   assign surr_lo = u8hex_pkg::SURR_LO_BASE + {6'd0, cp_off[9:0]};

   always_comb begin
      pcount_in           = pcount_ff;
      seqlen_in           = seqlen_ff;
      pend_in             = pend_ff;
      push_group.units    = '0;
      push_group.count    = 2'd0;
      push_group.text_end = req_string_end;
      if (pcount_ff == 2'd0) begin
         if (new_len >= 3'd2 && !req_string_end) begin
            pend_in[0] = req_data_byte;
            pcount_in  = 2'd1;
            seqlen_in  = new_len;
         end else begin
            push_group.count = 2'd1;
            push_group.units[0] = (new_len == 3'd1) ? {8'h00, req_data_byte}
                                                    : u8hex_pkg::QMARK_UNIT;
         end
      end else if (seq_full) begin
         pcount_in = 2'd0;
         seqlen_in = 3'd0;
         if (|cp[20:16]) begin
            push_group.count    = 2'd2;
            push_group.units[0] = surr_hi;
            push_group.units[1] = surr_lo;
         end else begin
            push_group.count    = 2'd1;
            push_group.units[0] = cp[15:0];
         end
      end else if (!req_string_end) begin
         case (pcount_ff)
            2'd1:    pend_in[1] = req_data_byte;
            default: pend_in[2] = req_data_byte;
         endcase
         pcount_in = pcount_ff + 2'd1;
      end else begin
         // string ends inside a sequence: lead becomes '?', the rest start over
         pcount_in           = 2'd0;
         seqlen_in           = 3'd0;
         push_group.units[0] = u8hex_pkg::QMARK_UNIT;
         if (pcount_ff == 2'd1) begin
            push_group.count    = 2'd2;
            push_group.units[1] = u8hex_pkg::single_unit(x0);
         end else if (u8hex_pkg::lead_len(x0) == 3'd2) begin
            push_group.count    = 2'd2;
            push_group.units[1] = {5'd0, x0[4:0], x1[5:0]};
         end else begin
            push_group.count    = 2'd3;
            push_group.units[1] = u8hex_pkg::single_unit(x0);
            push_group.units[2] = u8hex_pkg::single_unit(x1);
         end
      end
   end

   assign push = accept && (push_group.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= 2'd0;
         seqlen_ff <= 3'd0;
      end else if (accept) begin
         pcount_ff <= pcount_in;
         seqlen_ff <= seqlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

// ----- hdl/u8hex_fifo.sv -----
// Short queue of code-unit groups between the front and back ends.
module u8hex_fifo #(
   parameter int DEPTH = u8hex_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  u8hex_pkg::group_type   push_group,
   output logic                   full,
   input  logic                   pop,
   output u8hex_pkg::group_type   pop_group,
   output logic                   not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   u8hex_pkg::group_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_group = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// ----- hdl/u8hex_back.sv -----
// Back end: serializes code-unit groups into hex characters behind an output register.
module u8hex_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_not_empty,
   input  u8hex_pkg::group_type   queue_group,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [6:0]             rsp_hex_char,
   output logic                   rsp_run_last,
   output logic                   rsp_text_done
);

   u8hex_pkg::group_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] unit_ff, unit_in;
   logic [1:0] digit_ff, digit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_hex_char_ff, rsp_hex_char_in;
   logic       rsp_run_last_ff, rsp_run_last_in;
   logic       rsp_text_done_ff, rsp_text_done_in;

   logic [15:0] sel_unit;
   logic [3:0]  nibble;
   logic        emit, last_digit, last_unit, finish;

   always_comb begin
      case (unit_ff)
         2'd0:    sel_unit = cur_ff.units[0];
         2'd1:    sel_unit = cur_ff.units[1];
         default: sel_unit = cur_ff.units[2];
      endcase
      case (digit_ff)
         2'd0:    nibble = sel_unit[15:12];
         2'd1:    nibble = sel_unit[11:8];
         2'd2:    nibble = sel_unit[7:4];
         default: nibble = sel_unit[3:0];
      endcase
   end

   assign emit       = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign last_digit = (digit_ff == 2'd3);
   assign last_unit  = (unit_ff == (cur_ff.count - 2'd1));
   assign finish     = emit && last_digit && last_unit;
   assign pop        = queue_not_empty && (!cur_valid_ff || finish);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      unit_in      = unit_ff;
      digit_in     = digit_ff;
      if (pop) begin
         cur_in       = queue_group;
         cur_valid_in = 1'b1;
         unit_in      = 2'd0;
         digit_in     = 2'd0;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         digit_in = digit_ff + 2'd1;
         if (last_digit) unit_in = unit_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_hex_char_in  = rsp_hex_char_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      rsp_text_done_in = rsp_text_done_ff;
      if (emit) begin
         rsp_valid_in     = 1'b1;
         rsp_hex_char_in  = u8hex_pkg::hex_ascii(nibble);
         rsp_run_last_in  = last_digit && last_unit;
         rsp_text_done_in = last_digit && last_unit && cur_ff.text_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unit_ff      <= 2'd0;
         digit_ff     <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         unit_ff      <= unit_in;
         digit_ff     <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff           <= cur_in;
      rsp_hex_char_ff  <= rsp_hex_char_in;
      rsp_run_last_ff  <= rsp_run_last_in;
      rsp_text_done_ff <= rsp_text_done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hex_char  = rsp_hex_char_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_text_done = rsp_text_done_ff;

endmodule

// ----- hdl/u8hex_props.sv -----
// Port-level checks for the transcoder, bound to the top level.
module u8hex_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_string_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_hex_char,
   input logic       rsp_run_last,
   input logic       rsp_text_done
);

   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_done |-> rsp_run_last)
      else $error("text_done without run_last");

   a_hex_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_hex_char >= 7'h30 && rsp_hex_char <= 7'h39) ||
                     (rsp_hex_char >= 7'h41 && rsp_hex_char <= 7'h46)))
      else $error("output character is not an uppercase hex digit");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hex_char) &&
                                  $stable(rsp_run_last) && $stable(rsp_text_done))
      else $error("stalled result item changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data_byte) &&
                                  $stable(req_string_end))
      else $error("waiting input item changed");

endmodule

bind utf8_to_utf16be_hex u8hex_props u_props (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_data_byte  (req_data_byte),
   .req_string_end (req_string_end),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hex_char   (rsp_hex_char),
   .rsp_run_last   (rsp_run_last),
   .rsp_text_done  (rsp_text_done)
);

// ----- tb/sv/tb_utf8_to_utf16be_hex.sv -----
// Testbench for utf8_to_utf16be_hex: directed and random UTF-8 strings checked against an in-bench decoder.
`timescale 1ns / 100ps

module tb_utf8_to_utf16be_hex;

   localparam int TOTAL_BYTES = 280;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [7:0] data;
      logic       text_end;
   } text_byte_type;

   typedef struct packed {
      logic [6:0] hex_char;
      logic       run_last;
      logic       text_done;
   } hex_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_string_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_hex_char;
   logic       rsp_run_last;
   logic       rsp_text_done;

   text_byte_type byte_stream[$];
   logic [7:0]    text_bytes[$];
   hex_out_type   expected_chars[$];
   hex_out_type   want;

   // decoder state: bytes of an unfinished sequence
   logic [7:0] held_bytes[3];
   logic [1:0] held_count;
   logic [2:0] held_len;

   logic req_taken = 1'b0;
   int   bytes_taken = 0;
   int   total_bytes = TOTAL_BYTES;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   int   holds_done = 0;

   utf8_to_utf16be_hex uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hex_char   (rsp_hex_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_text_done  (rsp_text_done)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int lead_length(input logic [7:0] c);
      int len;
      if (c < 8'h80)                  len = 1;
      else if ((c & 8'hE0) == 8'hC0)  len = 2;
      else if ((c & 8'hF0) == 8'hE0)  len = 3;
      else if ((c & 8'hF8) == 8'hF0)  len = 4;
      else                            len = 0;
      return len;
   endfunction

   // Decode one byte against the held sequence and queue the hex characters it causes.
   task automatic transcode_byte(input logic [7:0] data, input logic text_end);
      logic [7:0]  seq[4];
      logic [15:0] units[4];
      logic [20:0] cp;
      logic [3:0]  nib;
      hex_out_type ch;
      int          n, i, k, d, nu, len, hold, hold_len;
      bit          stop, got;
      n = int'(held_count);
      for (k = 0; k < n; k++) seq[k] = held_bytes[k];
      seq[n] = data;
      n = n + 1;
      i = 0;
      nu = 0;
      hold = 0;
      hold_len = 0;
      stop = 0;
      cp = '0;
      while (i < n && !stop) begin
         len = lead_length(seq[i]);
         got = 1;
         if (len == 1) begin
            cp = {13'd0, seq[i]};
            i = i + 1;
         end else if (len == 0) begin
            cp = 21'h3F;
            i = i + 1;
         end else if (i + len <= n) begin
            case (len)
               2: cp = {10'd0, seq[i][4:0], seq[i+1][5:0]};
               3: cp = {5'd0, seq[i][3:0], seq[i+1][5:0], seq[i+2][5:0]};
               default: cp = {seq[i][2:0], seq[i+1][5:0], seq[i+2][5:0], seq[i+3][5:0]};
            endcase
            i = i + len;
         end else if (!text_end) begin
            hold = n - i;
            hold_len = len;
            stop = 1;
            got = 0;
         end else begin
            // string ended inside a sequence: lead becomes '?', rest decoded afresh
            cp = 21'h3F;
            i = i + 1;
         end
         if (got) begin
            if (nu >= 4) begin
               stop = 1;
            end else if (cp > 21'hFFFF) begin
               cp = cp - 21'h10000;
               units[nu] = 16'hD800 + {5'd0, cp[20:10]};
               nu = nu + 1;
               if (nu < 4) begin
                  units[nu] = 16'hDC00 + {6'd0, cp[9:0]};
                  nu = nu + 1;
               end
            end else begin
               units[nu] = cp[15:0];
               nu = nu + 1;
            end
         end
      end
      if (hold > 3) hold = 3;
      for (k = 0; k < hold; k++) held_bytes[k] = seq[i + k];
      held_count = hold[1:0];
      held_len = (hold != 0) ? hold_len[2:0] : 3'd0;
      for (k = 0; k < nu; k++) begin
         for (d = 0; d < 4; d++) begin
            nib = units[k][15 - 4*d -: 4];
            ch.hex_char = (nib < 4'd10) ? 7'h30 + {3'd0, nib} : 7'h41 + {3'd0, nib} - 7'd10;
            ch.run_last = (k == nu - 1) && (d == 3);
            ch.text_done = ch.run_last && text_end;
            expected_chars.push_back(ch);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("mismatch: %s got 0x%0h want 0x%0h (cycle %0d)", what, got, exp_val,
               cycle_count);
      mismatch_count++;
   endtask

   // Move the assembled string into the send queue, flagging its last byte.
   task automatic commit_text();
      text_byte_type it;
      for (int k = 0; k < text_bytes.size(); k++) begin
         it.data = text_bytes[k];
         it.text_end = (k == text_bytes.size() - 1);
         byte_stream.push_back(it);
      end
      text_bytes.delete();
   endtask

   function automatic logic [7:0] cont_byte();
      logic [7:0] b;
      if ($urandom_range(15) == 0) b = 8'($urandom_range(255));
      else                         b = 8'h80 | 8'($urandom_range(63));
      return b;
   endfunction

   function automatic int send_idle_pct();
      int pct;
      if (bytes_taken < total_bytes / 3)          pct = 7;
      else if (bytes_taken < 2 * total_bytes / 3) pct = 55;
      else                                        pct = 0;
      return pct;
   endfunction

   function automatic int recv_stall_pct();
      int pct;
      if (bytes_taken < total_bytes / 3)          pct = 55;
      else if (bytes_taken < 2 * total_bytes / 3) pct = 7;
      else                                        pct = 0;
      return pct;
   endfunction

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (byte_stream.size() > 0 &&
             (hold_left > 0 || $urandom_range(99) >= send_idle_pct())) begin
            req_valid <= 1'b1;
            req_data_byte <= byte_stream[0].data;
            req_string_end <= byte_stream[0].text_end;
            byte_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with long hold-offs that back the block up into its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_done < 2 && bytes_taken >= 60 + 120 * holds_done) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct());
      end
   end

   // input tracking and output checking
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         held_count = 2'd0;
         held_len = 3'd0;
         for (int k = 0; k < 3; k++) held_bytes[k] = 8'h00;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            transcode_byte(req_data_byte, req_string_end);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected item", int'(rsp_hex_char), 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_hex_char !== want.hex_char)
                  report_mismatch("hex_char", int'(rsp_hex_char), int'(want.hex_char));
               if (rsp_run_last !== want.run_last)
                  report_mismatch("run_last", int'(rsp_run_last), int'(want.run_last));
               if (rsp_text_done !== want.text_done)
                  report_mismatch("text_done", int'(rsp_text_done), int'(want.text_done));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int nchars, kind, len;
      // directed strings
      text_bytes = '{8'h00};                      commit_text();
      text_bytes = '{8'h7F, 8'hC3, 8'hA9};        commit_text();
      text_bytes = '{8'hE2, 8'h82, 8'hAC};        commit_text();
      text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80}; commit_text();
      // invalid leads
      text_bytes = '{8'h80, 8'hBF, 8'hF8, 8'hFF}; commit_text();
      // largest 4-byte form, no upper bound check
      text_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF}; commit_text();
      // strings that end inside a sequence
      text_bytes = '{8'hF0, 8'h41, 8'h41};        commit_text();
      text_bytes = '{8'hE2};                      commit_text();
      text_bytes = '{8'hF0, 8'hC3, 8'hA9};        commit_text();

      while (byte_stream.size() < TOTAL_BYTES) begin
         nchars = $urandom_range(1, 6);
         repeat (nchars) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
               text_bytes.push_back(8'($urandom_range(127)));
            end else if (kind < 50) begin
               text_bytes.push_back(8'hC0 | 8'($urandom_range(31)));
               text_bytes.push_back(cont_byte());
            end else if (kind < 65) begin
               text_bytes.push_back(8'hE0 | 8'($urandom_range(15)));
               repeat (2) text_bytes.push_back(cont_byte());
            end else if (kind < 80) begin
               text_bytes.push_back(8'hF0 | 8'($urandom_range(7)));
               repeat (3) text_bytes.push_back(cont_byte());
            end else if (kind < 88) begin
               if ($urandom_range(1)) text_bytes.push_back(8'h80 | 8'($urandom_range(63)));
               else                   text_bytes.push_back(8'hF8 | 8'($urandom_range(7)));
            end else if (kind < 95) begin
               // truncated sequence
               len = $urandom_range(2, 4);
               case (len)
                  2:       text_bytes.push_back(8'hC0 | 8'($urandom_range(31)));
                  3:       text_bytes.push_back(8'hE0 | 8'($urandom_range(15)));
                  default: text_bytes.push_back(8'hF0 | 8'($urandom_range(7)));
               endcase
               repeat ($urandom_range(0, len - 2)) text_bytes.push_back(cont_byte());
            end else begin
               text_bytes.push_back(8'($urandom_range(255)));
            end
         end
         commit_text();
      end
      total_bytes = byte_stream.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_stream.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/u8hex_pkg.sv
hdl/u8hex_front.sv
hdl/u8hex_fifo.sv
hdl/u8hex_back.sv
hdl/utf8_to_utf16be_hex.sv
hdl/u8hex_props.sv
tb/sv/tb_utf8_to_utf16be_hex.sv
